// ===== rtl/core/contact_force_pressure_smoother_assert.svh =====
// assertion macros for the contact force pressure smoother
// expects clk and rst in the scope of the including module
`ifndef CONTACT_FORCE_PRESSURE_SMOOTHER_ASSERT_SVH
`define CONTACT_FORCE_PRESSURE_SMOOTHER_ASSERT_SVH

// condition holds at every edge out of reset
`define CFPS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CFPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cfps_pkg.sv =====
// shared types and fixed widths for the contact force pressure smoother
// no dependencies
package cfps_pkg;

  localparam int FORCE_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int PRESSURE_W = 32;
  localparam int MAG_W      = 24;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int PROD_W     = MAG_W + GAIN_W;
  localparam int ROOT_CW    = $clog2(MAG_W);

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      is_contact;
    logic                      last_of_message;
  } force_beat_t;

  typedef struct packed {
    logic [PRESSURE_W-1:0] pressure_mean;
    logic                  contact_seen;
    logic                  contacts_dropped;
  } result_beat_t;

endpackage

// ===== rtl/core/cfps_if.sv =====
// valid/ready channel interfaces for force beats, result beats and gain writes
// depends on cfps_pkg
interface cfps_force_if;
  logic                      valid;
  logic                      ready;
  cfps_pkg::force_beat_t     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cfps_result_if;
  logic                      valid;
  logic                      ready;
  cfps_pkg::result_beat_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cfps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cfps_pkg::GAIN_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/cfps_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module cfps_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/contact_force_pressure_smoother.sv =====
// contact force pressure smoother top level: message averaging, magnitude, window mean
// depends on cfps_pkg, cfps_if, cfps_ram and contact_force_pressure_smoother_assert.svh
//
//   channel   dir   payload                                         beat when
//   forces    in    force_x/y/z, is_contact, last_of_message        valid & ready
//   results   out   pressure_mean, contact_seen, contacts_dropped   valid & ready
//   cfg       in    scale_gain                                      valid & ready
//
// a beat that does not close a message only updates the message accumulation, and the block stays ready
// a closing beat with contacts runs the serial divider (one quotient bit a cycle, three
// axes in turn), the serial square root (one root bit a cycle), the gain multiply and
// the chunked mean multiply; a closing beat without contacts goes straight to the window
// update and the chunked mean multiply
// reset is synchronous; window entries carry valid bits, so there is no clearing pass
// a result waits in the output register while further beats of the next message enter
module contact_force_pressure_smoother #(
  parameter int WINDOW_DEPTH = 8,
  parameter int MAX_CONTACTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  cfps_force_if.sink      forces,
  cfps_result_if.source   results,
  cfps_cfg_if.sink        cfg
);
  import cfps_pkg::*;

  localparam int CW  = $clog2(MAX_CONTACTS + 1);
  localparam int SW  = FORCE_W + $clog2(MAX_CONTACTS);
  localparam int WW  = $clog2(WINDOW_DEPTH + 1);
  localparam int TW  = PRESSURE_W + $clog2(WINDOW_DEPTH);
  localparam int DW  = SW;
  localparam int VW  = CW;
  localparam int SCW = $clog2(DW + 1);
  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int EW  = PRESSURE_W + 1;
  localparam int RS  = TW + $clog2(WINDOW_DEPTH);
  localparam int RCW = 16;
  localparam int RCN = (RS + RCW) / RCW;
  localparam int RMW = RCN * RCW;
  localparam int MAW = TW + RMW;
  localparam logic [RMW-1:0] RECIP =
    RMW'(((64'd1 << RS) + 64'(WINDOW_DEPTH - 1)) / 64'(WINDOW_DEPTH));

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DLOAD = 11'b000_0000_0010,
    S_DITER = 11'b000_0000_0100,
    S_MUL   = 11'b000_0000_1000,
    S_ACC   = 11'b000_0001_0000,
    S_SQRT  = 11'b000_0010_0000,
    S_GAIN  = 11'b000_0100_0000,
    S_WIN   = 11'b000_1000_0000,
    S_MLOAD = 11'b001_0000_0000,
    S_MITER = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] gain;

  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  logic signed [SW-1:0] sum_x_next, sum_y_next, sum_z_next;
  logic [CW-1:0]        msg_count, msg_count_next;
  logic                 overflow_seen, overflow_next;
  logic                 msg_has;
  logic                 accept;

  logic [1:0]           ax_sel;
  logic signed [SW-1:0] sel_sum;
  logic [SW-1:0]        sel_u, sel_abs;

  logic [DW-1:0]  div_quo, div_quo_step;
  logic [VW-1:0]  div_rem, div_rem_step, div_den;
  logic [VW:0]    div_sh;
  logic           div_ge;
  logic [SCW-1:0] div_cnt;

  logic [SQ_W-1:0]    sq_prod, sq_acc, sq_sum, sq_rad;
  logic [MAG_W+1:0]   sq_rem, sqrt_sh, sqrt_trial, sq_rem_step;
  logic [MAG_W-1:0]   sq_root, sq_root_step;
  logic               sqrt_ge;
  logic [ROOT_CW-1:0] sq_cnt;
  logic [PROD_W-1:0]  gain_prod;

  logic [WINDOW_DEPTH-1:0] win_valid;
  logic [AW-1:0]           wp;
  logic [TW-1:0]           win_total, total_next;
  logic [WW-1:0]           win_count, wcnt_next;
  logic [EW-1:0]           ram_rd;
  logic                    ram_we, ram_re;
  logic [PRESSURE_W-1:0]   old_p, sample;
  logic                    old_c;

  logic [RMW-1:0]     mean_rcp;
  logic [TW+RCW-1:0]  mean_pp;
  logic [MAW-1:0]     mean_acc, mean_acc_next;

  logic         out_valid;
  result_beat_t out_data;

  assign accept        = forces.valid && forces.ready;
  assign forces.ready  = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // per message accumulation
  always_comb begin
    sum_x_next     = sum_x;
    sum_y_next     = sum_y;
    sum_z_next     = sum_z;
    msg_count_next = msg_count;
    overflow_next  = overflow_seen;
    if (accept && forces.data.is_contact) begin
      if (msg_count < CW'(MAX_CONTACTS)) begin
        sum_x_next     = sum_x + SW'(forces.data.force_x);
        sum_y_next     = sum_y + SW'(forces.data.force_y);
        sum_z_next     = sum_z + SW'(forces.data.force_z);
        msg_count_next = msg_count + 1'b1;
      end else begin
        overflow_next = 1'b1;
      end
    end
  end

  always_comb begin
    case (ax_sel)
      AXIS_X:  sel_sum = sum_x;
      AXIS_Y:  sel_sum = sum_y;
      default: sel_sum = sum_z;
    endcase
    sel_u   = sel_sum;
    sel_abs = sel_u[SW-1] ? (~sel_u + 1'b1) : sel_u;
  end

  // restoring divider step
  always_comb begin
    div_sh       = {div_rem, div_quo[DW-1]};
    div_ge       = (div_sh >= {1'b0, div_den});
    div_rem_step = div_ge ? VW'(div_sh - {1'b0, div_den}) : div_sh[VW-1:0];
    div_quo_step = {div_quo[DW-2:0], div_ge};
  end

  // square root step, two radicand bits per cycle
  always_comb begin
    sqrt_sh      = {sq_rem[MAG_W-1:0], sq_rad[SQ_W-1 -: 2]};
    sqrt_trial   = {sq_root, 2'b01};
    sqrt_ge      = (sqrt_sh >= sqrt_trial);
    sq_rem_step  = sqrt_ge ? (sqrt_sh - sqrt_trial) : sqrt_sh;
    sq_root_step = {sq_root[MAG_W-2:0], sqrt_ge};
  end

  assign sq_sum = sq_acc + sq_prod;

  // window mean by reciprocal multiply, one chunk a cycle, top chunk first
  always_comb begin
    mean_pp       = win_total * mean_rcp[RMW-1 -: RCW];
    mean_acc_next = {mean_acc[MAW-RCW-1:0], {RCW{1'b0}}} + MAW'(mean_pp);
  end

  // window update
  always_comb begin
    old_p      = win_valid[wp] ? ram_rd[PRESSURE_W-1:0] : '0;
    old_c      = win_valid[wp] & ram_rd[PRESSURE_W];
    sample     = msg_has ? gain_prod[PROD_W-1:GAIN_FRAC] : '0;
    total_next = win_total - TW'(old_p) + TW'(sample);
    wcnt_next  = win_count - WW'(old_c) + WW'(msg_has);
  end

  assign ram_we = (state == S_WIN);
  assign ram_re = accept && forces.data.last_of_message;

  cfps_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata ({msg_has, sample}),
    .re    (ram_re),
    .raddr (wp),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gain          <= GAIN_RESET;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      msg_count     <= '0;
      overflow_seen <= 1'b0;
      win_valid     <= '0;
      wp            <= '0;
      win_total     <= '0;
      win_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        gain <= cfg.data;
      end
      if (state == S_EMIT && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          sum_x         <= sum_x_next;
          sum_y         <= sum_y_next;
          sum_z         <= sum_z_next;
          msg_count     <= msg_count_next;
          overflow_seen <= overflow_next;
          if (accept && forces.data.last_of_message) begin
            msg_has <= (msg_count_next != '0);
            sq_acc  <= '0;
            ax_sel  <= AXIS_X;
            state   <= (msg_count_next != '0) ? S_DLOAD : S_WIN;
          end
        end
        S_DLOAD: begin
          div_quo <= DW'(sel_abs);
          div_den <= VW'(msg_count);
          div_rem <= '0;
          div_cnt <= '0;
          state   <= S_DITER;
        end
        S_DITER: begin
          div_quo <= div_quo_step;
          div_rem <= div_rem_step;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == SCW'(DW - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          sq_prod <= div_quo[MAG_W-1:0] * div_quo[MAG_W-1:0];
          state   <= S_ACC;
        end
        S_ACC: begin
          sq_acc <= sq_sum;
          if (ax_sel == AXIS_Z) begin
            sq_rad  <= sq_sum;
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= '0;
            state   <= S_SQRT;
          end else begin
            ax_sel <= ax_sel + 1'b1;
            state  <= S_DLOAD;
          end
        end
        S_SQRT: begin
          sq_rad  <= {sq_rad[SQ_W-3:0], 2'b00};
          sq_rem  <= sq_rem_step;
          sq_root <= sq_root_step;
          sq_cnt  <= sq_cnt + 1'b1;
          if (sq_cnt == ROOT_CW'(MAG_W - 1)) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          gain_prod <= sq_root * gain;
          state     <= S_WIN;
        end
        S_WIN: begin
          win_total     <= total_next;
          win_count     <= wcnt_next;
          win_valid[wp] <= 1'b1;
          wp            <= (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
          state         <= S_MLOAD;
        end
        S_MLOAD: begin
          mean_acc <= '0;
          mean_rcp <= RECIP;
          div_cnt  <= '0;
          state    <= S_MITER;
        end
        S_MITER: begin
          mean_acc <= mean_acc_next;
          mean_rcp <= {mean_rcp[RMW-RCW-1:0], {RCW{1'b0}}};
          div_cnt  <= div_cnt + 1'b1;
          if (div_cnt == SCW'(RCN - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || results.ready) begin
            out_data.pressure_mean    <= mean_acc[RS +: PRESSURE_W];
            out_data.contact_seen     <= (win_count != '0);
            out_data.contacts_dropped <= overflow_seen;
            sum_x                     <= '0;
            sum_y                     <= '0;
            sum_z                     <= '0;
            msg_count                 <= '0;
            overflow_seen             <= 1'b0;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "contact_force_pressure_smoother_assert.svh"

  `CFPS_ASSERT_ALWAYS(a_count_bound, msg_count <= CW'(MAX_CONTACTS), "contact count past bound")
  `CFPS_ASSERT_ALWAYS(a_win_count, win_count <= $countones(win_valid), "window contact count off")
  `CFPS_ASSERT_IMPL(a_div_rem, (state == S_DITER), div_rem < div_den, "divider remainder not below divisor")
  `CFPS_ASSERT_NEXT(a_emit, (state == S_EMIT && (!out_valid || results.ready)), (out_valid && state == S_IDLE), "result beat not loaded")

endmodule

// ===== tb/sv/contact_force_pressure_smoother_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for contact_force_pressure_smoother: force beats in, window reports out
// predicts each report from its own model of averaging, magnitude, gain and window mean
// depends on cfps_pkg, the cfps channel interfaces and the rtl top level
module contact_force_pressure_smoother_tb;
  import cfps_pkg::*;

  localparam int WINDOW_DEPTH  = 8;
  localparam int MAX_CONTACTS  = 64;
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_BEATS  = 1400;
  localparam int GAIN_PHASES   = 6;
  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  logic clk;
  logic rst;
  bit   no_gaps;
  int   mismatches;
  int   beats_sent;

  logic [GAIN_W-1:0]     gain_model;
  longint                msg_sum_x;
  longint                msg_sum_y;
  longint                msg_sum_z;
  int                    msg_contacts;
  bit                    msg_overflow;
  logic [PRESSURE_W-1:0] pressure_hist [WINDOW_DEPTH];
  bit                    contact_hist [WINDOW_DEPTH];
  longint unsigned       hist_total;
  int                    hist_contacts;
  result_beat_t          window_reports [$];

  cfps_force_if  forces_bus ();
  cfps_result_if results_bus ();
  cfps_cfg_if    gain_bus ();

  contact_force_pressure_smoother #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MAX_CONTACTS(MAX_CONTACTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .forces(forces_bus),
    .results(results_bus),
    .cfg(gain_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int pick;
    if (no_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_message();
    msg_sum_x = 0;
    msg_sum_y = 0;
    msg_sum_z = 0;
    msg_contacts = 0;
    msg_overflow = 1'b0;
  endfunction

  function automatic void reset_model();
    int i;
    gain_model = GAIN_RESET;
    clear_message();
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      pressure_hist[i] = '0;
      contact_hist[i] = 1'b0;
    end
    hist_total = 0;
    hist_contacts = 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic void smooth_beat(force_beat_t b);
    longint                n;
    longint                avg_x;
    longint                avg_y;
    longint                avg_z;
    longint unsigned       len_sq;
    longint unsigned       mag;
    longint unsigned       scaled;
    longint unsigned       mean;
    logic [PRESSURE_W-1:0] pressure;
    bit                    touched;
    result_beat_t          report;
    int                    i;
    pressure = '0;
    touched = 1'b0;
    if (b.is_contact) begin
      if (msg_contacts < MAX_CONTACTS) begin
        msg_sum_x += longint'($signed(b.force_x));
        msg_sum_y += longint'($signed(b.force_y));
        msg_sum_z += longint'($signed(b.force_z));
        msg_contacts++;
      end else begin
        msg_overflow = 1'b1;
      end
    end
    if (!b.last_of_message) return;
    if (msg_contacts > 0) begin
      n = longint'(msg_contacts);
      avg_x = msg_sum_x / n;
      avg_y = msg_sum_y / n;
      avg_z = msg_sum_z / n;
      len_sq = avg_x * avg_x + avg_y * avg_y + avg_z * avg_z;
      mag = int_sqrt(len_sq);
      scaled = (mag * 64'(gain_model)) >> GAIN_FRAC;
      if (scaled > 64'hFFFF_FFFF) scaled = 64'hFFFF_FFFF;
      pressure = scaled[PRESSURE_W-1:0];
      touched = 1'b1;
    end
    hist_total -= 64'(pressure_hist[WINDOW_DEPTH-1]);
    hist_contacts -= int'(contact_hist[WINDOW_DEPTH-1]);
    for (i = WINDOW_DEPTH - 1; i > 0; i--) begin
      pressure_hist[i] = pressure_hist[i-1];
      contact_hist[i] = contact_hist[i-1];
    end
    pressure_hist[0] = pressure;
    contact_hist[0] = touched;
    hist_total += 64'(pressure);
    hist_contacts += int'(touched);
    mean = hist_total / 64'(WINDOW_DEPTH);
    if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
    report.pressure_mean = mean[PRESSURE_W-1:0];
    report.contact_seen = (hist_contacts != 0);
    report.contacts_dropped = msg_overflow;
    window_reports.push_back(report);
    clear_message();
  endfunction

  function automatic void flag_mismatch(input string field,
                                        input logic [PRESSURE_W-1:0] want,
                                        input logic [PRESSURE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d at %0t on %s: expected %0h, got %0h",
               mismatches, $realtime, field, want, got);
    end
  endfunction

  function automatic void check_report(result_beat_t got);
    result_beat_t want;
    if (window_reports.size() == 0) begin
      flag_mismatch("unexpected result beat", '0, got.pressure_mean);
      return;
    end
    want = window_reports.pop_front();
    if (got.pressure_mean !== want.pressure_mean) begin
      flag_mismatch("pressure_mean", want.pressure_mean, got.pressure_mean);
    end
    if (got.contact_seen !== want.contact_seen) begin
      flag_mismatch("contact_seen", PRESSURE_W'(want.contact_seen),
                    PRESSURE_W'(got.contact_seen));
    end
    if (got.contacts_dropped !== want.contacts_dropped) begin
      flag_mismatch("contacts_dropped", PRESSURE_W'(want.contacts_dropped),
                    PRESSURE_W'(got.contacts_dropped));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && results_bus.valid === 1'b1 && results_bus.ready === 1'b1) begin
      check_report(results_bus.data);
    end
  end

  // result side backpressure
  initial begin : result_stall
    int hold;
    hold = 0;
    results_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_gaps) begin
        results_bus.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        results_bus.ready <= 1'b0;
        hold--;
      end else begin
        results_bus.ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((forces_bus.valid === 1'b1 && forces_bus.ready === 1'b1) ||
          (results_bus.valid === 1'b1 && results_bus.ready === 1'b1) ||
          (gain_bus.valid === 1'b1 && gain_bus.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [FORCE_W-1:0] rand_force();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return FORCE_W'($urandom);
    if (pick < 8) return FORCE_W'($urandom_range(0, 8191) - 4096);
    case ($urandom_range(0, 4))
      0: return FORCE_MAX;
      1: return FORCE_MIN;
      2: return '0;
      3: return '1;
      default: return FORCE_W'(1);
    endcase
  endfunction

  function automatic force_beat_t make_beat(input logic signed [FORCE_W-1:0] fx, fy, fz,
                                            input logic touch, closes);
    force_beat_t b;
    b.force_x = fx;
    b.force_y = fy;
    b.force_z = fz;
    b.is_contact = touch;
    b.last_of_message = closes;
    return b;
  endfunction

  function automatic force_beat_t rand_beat(input logic touch, closes);
    return make_beat(rand_force(), rand_force(), rand_force(), touch, closes);
  endfunction

  task automatic send_beat(input force_beat_t beat);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      forces_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    forces_bus.data  <= beat;
    forces_bus.valid <= 1'b1;
    do @(posedge clk); while (forces_bus.ready !== 1'b1);
    beats_sent++;
    smooth_beat(beat);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    forces_bus.valid <= 1'b0;
    while (window_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] gain);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    gain_bus.data  <= gain;
    gain_bus.valid <= 1'b1;
    do @(posedge clk); while (gain_bus.ready !== 1'b1);
    gain_model = gain;
    @(negedge clk);
    gain_bus.valid <= 1'b0;
  endtask

  // count contact beats, with quiet beats mixed in; optionally closed by a quiet beat
  task automatic send_contacts(input int count, input int noise_pct, input bit close_quiet);
    int left;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(rand_beat(1'b0, 1'b0));
      end else begin
        left--;
        send_beat(rand_beat(1'b1, !close_quiet && left == 0));
      end
    end
    if (close_quiet) send_beat(rand_beat(1'b0, 1'b1));
  endtask

  task automatic send_random_message();
    int kind;
    if ($urandom_range(0, 99) < 3) hold_until_drained();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      send_beat(rand_beat(1'b0, 1'b1));
    end else if (kind < 14) begin
      send_contacts($urandom_range(MAX_CONTACTS - 2, MAX_CONTACTS + 6), 5,
                    1'($urandom_range(0, 1)));
    end else if (kind < 26) begin
      send_contacts($urandom_range(1, 6), 20, 1'b1);
    end else begin
      send_contacts($urandom_range(1, $urandom_range(1, 8)), 5, 1'b0);
    end
  endtask

  task automatic test_extremes();
    send_beat(make_beat(FORCE_MAX, FORCE_MAX, FORCE_MAX, 1'b1, 1'b1));
    send_beat(make_beat(FORCE_MIN, FORCE_MIN, FORCE_MIN, 1'b1, 1'b1));
    send_beat(make_beat('0, '0, '0, 1'b1, 1'b1));
    send_beat(make_beat(FORCE_MAX, FORCE_MIN, '0, 1'b1, 1'b0));
    send_beat(make_beat(-24'sd1, 24'sd1, FORCE_MIN, 1'b1, 1'b1));
    // negative averages truncate toward zero
    send_beat(make_beat(-24'sd3, 24'sd5, -24'sd7, 1'b1, 1'b0));
    send_beat(make_beat('0, '0, '0, 1'b1, 1'b0));
    send_beat(make_beat('0, '0, '0, 1'b1, 1'b1));
  endtask

  task automatic test_no_contact();
    int i;
    send_beat(make_beat('1, '1, '1, 1'b0, 1'b1));
    send_beat(make_beat(FORCE_MAX, '0, FORCE_MIN, 1'b1, 1'b0));
    send_beat(make_beat(FORCE_MAX, FORCE_MAX, FORCE_MAX, 1'b0, 1'b0));
    send_beat(make_beat(FORCE_MIN, '1, 24'sd4096, 1'b1, 1'b1));
    send_beat(make_beat(FORCE_MIN, FORCE_MIN, FORCE_MIN, 1'b0, 1'b0));
    send_beat(make_beat('0, '0, '0, 1'b0, 1'b1));
    send_beat(rand_beat(1'b1, 1'b0));
    send_beat(make_beat(FORCE_MAX, FORCE_MIN, FORCE_MAX, 1'b0, 1'b1));
    // flush the window so contact_seen falls back to zero
    for (i = 0; i < WINDOW_DEPTH; i++) send_beat(rand_beat(1'b0, 1'b1));
  endtask

  task automatic test_gain_extremes();
    write_gain('0);
    send_beat(make_beat(FORCE_MAX, FORCE_MAX, FORCE_MAX, 1'b1, 1'b1));
    write_gain('1);
    send_beat(make_beat(FORCE_MIN, FORCE_MIN, FORCE_MIN, 1'b1, 1'b1));
    send_beat(make_beat(FORCE_MIN, FORCE_MAX, FORCE_MIN, 1'b1, 1'b1));
    write_gain(16'd1);
    send_beat(make_beat(FORCE_MAX, '0, '0, 1'b1, 1'b1));
    write_gain(GAIN_RESET);
  endtask

  task automatic test_contact_overflow();
    int i;
    for (i = 0; i < MAX_CONTACTS; i++) begin
      send_beat(make_beat(FORCE_MAX, FORCE_MIN, FORCE_MAX, 1'b1, i == MAX_CONTACTS - 1));
    end
    send_contacts(MAX_CONTACTS + 1, 0, 1'b0);
    send_contacts(MAX_CONTACTS, 10, 1'b1);
    send_contacts(MAX_CONTACTS + 6, 10, 1'b1);
  endtask

  task automatic test_back_to_back();
    int i;
    no_gaps = 1'b1;
    for (i = 0; i < 12; i++) send_contacts($urandom_range(1, 4), 0, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int phase;
    start = beats_sent;
    for (phase = 0; phase < GAIN_PHASES; phase++) begin
      case (phase)
        0: write_gain(GAIN_RESET);
        1: write_gain('1);
        2: write_gain(GAIN_W'($urandom_range(0, 511)));
        3: write_gain('0);
        default: write_gain(GAIN_W'($urandom));
      endcase
      while (beats_sent - start < RANDOM_BEATS * (phase + 1) / GAIN_PHASES) begin
        send_random_message();
      end
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    no_gaps = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    forces_bus.valid = 1'b0;
    forces_bus.data = '0;
    gain_bus.valid = 1'b0;
    gain_bus.data = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_no_contact();
    test_gain_extremes();
    test_contact_overflow();
    test_back_to_back();
    test_random_traffic();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && window_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cfps_pkg.sv
rtl/core/cfps_if.sv
rtl/core/cfps_ram.sv
rtl/core/contact_force_pressure_smoother.sv
tb/sv/contact_force_pressure_smoother_tb.sv
